// File: design/spsrp_pkg.sv
// Shared types, constants and the field-walker control store for the SPS resolution parser.
// No dependencies; the other files that use it refer to it by scoped names.
package spsrp_pkg;

  localparam int CODE_BITS_DEF = 32;
  localparam int MB_SHIFT      = 4;
  localparam int STEP_W        = 5;
  localparam int SIZE_MAX      = 65535;

  localparam logic [7:0] PROFILE_BASELINE = 8'd66;
  localparam logic [7:0] PROFILE_HIGH     = 8'd100;

  typedef enum logic [1:0] {
    ST_OK,
    ST_TRUNC,
    ST_LONG,
    ST_RANGE
  } status_t;

  typedef enum logic [3:0] {
    OP_NEXT,
    OP_PROFILE,
    OP_POC_TYPE,
    OP_JUMP,
    OP_CYCLE_INIT,
    OP_CYCLE_LOOP,
    OP_WIDTH,
    OP_HEIGHT,
    OP_FRAME_ONLY,
    OP_CROP,
    OP_CROP_W,
    OP_CROP_H,
    OP_FINISH
  } op_t;

  typedef struct packed {
    logic              is_flag;
    op_t               op;
    logic [STEP_W-1:0] target;
  } uword_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BITS,
    S_EMIT
  } state_t;

  // One control word per syntax element, from the parameter set id onwards.
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    case (step)
      5'd0:    w = '{1'b0, OP_PROFILE,    5'd6};
      5'd1:    w = '{1'b0, OP_NEXT,       5'd0};
      5'd2:    w = '{1'b0, OP_NEXT,       5'd0};
      5'd3:    w = '{1'b0, OP_NEXT,       5'd0};
      5'd4:    w = '{1'b1, OP_NEXT,       5'd0};
      5'd5:    w = '{1'b1, OP_NEXT,       5'd0};
      5'd6:    w = '{1'b0, OP_NEXT,       5'd0};
      5'd7:    w = '{1'b0, OP_POC_TYPE,   5'd14};
      5'd8:    w = '{1'b0, OP_JUMP,       5'd14};
      5'd9:    w = '{1'b1, OP_NEXT,       5'd0};
      5'd10:   w = '{1'b0, OP_NEXT,       5'd0};
      5'd11:   w = '{1'b0, OP_NEXT,       5'd0};
      5'd12:   w = '{1'b0, OP_CYCLE_INIT, 5'd14};
      5'd13:   w = '{1'b0, OP_CYCLE_LOOP, 5'd14};
      5'd14:   w = '{1'b0, OP_NEXT,       5'd0};
      5'd15:   w = '{1'b1, OP_NEXT,       5'd0};
      5'd16:   w = '{1'b0, OP_WIDTH,      5'd0};
      5'd17:   w = '{1'b0, OP_HEIGHT,     5'd0};
      5'd18:   w = '{1'b1, OP_FRAME_ONLY, 5'd20};
      5'd19:   w = '{1'b1, OP_NEXT,       5'd0};
      5'd20:   w = '{1'b1, OP_NEXT,       5'd0};
      5'd21:   w = '{1'b1, OP_CROP,       5'd26};
      5'd22:   w = '{1'b0, OP_CROP_W,     5'd0};
      5'd23:   w = '{1'b0, OP_CROP_W,     5'd0};
      5'd24:   w = '{1'b0, OP_CROP_H,     5'd0};
      5'd25:   w = '{1'b0, OP_CROP_H,     5'd0};
      default: w = '{1'b1, OP_FINISH,     5'd0};
    endcase
    return w;
  endfunction

endpackage

// File: design/spsrp_byte_if.sv
// Input channel of the SPS resolution parser: one NAL unit byte per item.
// No dependencies.
interface spsrp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] sps_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, sps_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, sps_byte, first_byte, last_byte, output ready);
endinterface

// File: design/spsrp_res_if.sv
// Result channel of the SPS resolution parser: cropped size, profile flag and status.
// No dependencies.
interface spsrp_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_width;
  logic [15:0] out_height;
  logic        is_baseline;
  logic [1:0]  parse_status;

  modport source (output valid, out_width, out_height, is_baseline, parse_status, input ready);
  modport sink   (input valid, out_width, out_height, is_baseline, parse_status, output ready);
endinterface

// File: design/h264_sps_resolution_parser.sv
// H.264 SPS resolution parser top level: microcoded Exp-Golomb field walker.
// Depends on spsrp_pkg, spsrp_byte_if and spsrp_res_if.
//
// Feed one SPS NAL unit byte per item, the header byte marked with first_byte and the
// final byte with last_byte. The NAL header and the three bytes after it are only
// accepted; each later byte is then walked by the field walker, which reads one bit per
// cycle under a 32-entry microcode table indexed by the current syntax element and takes
// no new byte until all eight bits are done. A byte that ends the parse stops the walk
// early; the result then passes through the emit state into the output register once
// that is free, and waits there for the sink while the next header byte may already be
// taken. At most one result comes per NAL unit: cropped luma width and height saturated
// to 16 bits, a baseline flag and a status (ok, truncated, code too long, size out of
// range). Emulation-prevention bytes and scaling lists are not interpreted.
module h264_sps_resolution_parser #(
  parameter int CODE_BITS = spsrp_pkg::CODE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  spsrp_byte_if.sink        sps,
  spsrp_res_if.source       res
);

  localparam int ZC_W  = $clog2(CODE_BITS);
  localparam int ACC_W = CODE_BITS + 7;
  localparam int SW    = spsrp_pkg::STEP_W;

  spsrp_pkg::state_t  state, state_next;
  spsrp_pkg::status_t pend_status;
  spsrp_pkg::uword_t  uw;

  logic                 parse_done;
  logic [1:0]           byte_index;
  logic [SW-1:0]        field_step;
  logic                 code_phase;
  logic [ZC_W-1:0]      zero_count;
  logic [ZC_W-1:0]      suffix_left;
  logic [CODE_BITS-1:0] code_value;
  logic [CODE_BITS-1:0] cycle_left;
  logic [7:0]           profile;
  logic [ACC_W-1:0]     acc_w;
  logic [ACC_W-1:0]     acc_h;
  logic [7:0]           shift;
  logic [2:0]           bit_count;
  logic                 last_seen;

  logic                 take, slot_free, emit_load;
  logic                 bit_in, field_end, too_long, finish, ends;
  logic [CODE_BITS-1:0] field_val, code_shift, cycle_dec;
  logic [SW-1:0]        step_next;
  logic [ACC_W-1:0]     crop2;
  logic                 w_neg, w_big, h_neg, h_big, out_range;
  logic [15:0]          w_sat, h_sat;

  assign take      = sps.valid && sps.ready;
  assign slot_free = !res.valid || res.ready;
  assign emit_load = (state == spsrp_pkg::S_EMIT) && slot_free;

  // Field walker: one bit of the current byte per cycle.
  always_comb begin
    uw         = spsrp_pkg::ucode(field_step);
    bit_in     = shift[7];
    code_shift = {code_value[CODE_BITS-2:0], bit_in};
    cycle_dec  = cycle_left - CODE_BITS'(1);
    field_end  = 1'b0;
    field_val  = '0;
    too_long   = 1'b0;
    if (uw.is_flag) begin
      field_end = 1'b1;
      field_val = CODE_BITS'(bit_in);
    end else if (!code_phase) begin
      if (!bit_in) begin
        too_long = (zero_count == ZC_W'(CODE_BITS - 1));
      end else if (zero_count == '0) begin
        field_end = 1'b1;
      end
    end else if (suffix_left == ZC_W'(1)) begin
      field_end = 1'b1;
      field_val = code_shift - CODE_BITS'(1);
    end

    finish    = 1'b0;
    step_next = field_step + SW'(1);
    case (uw.op)
      spsrp_pkg::OP_PROFILE: begin
        if (profile < spsrp_pkg::PROFILE_HIGH) step_next = uw.target;
      end
      spsrp_pkg::OP_POC_TYPE: begin
        if (field_val == CODE_BITS'(1)) step_next = field_step + SW'(2);
        else if (field_val != '0) step_next = uw.target;
      end
      spsrp_pkg::OP_JUMP: step_next = uw.target;
      spsrp_pkg::OP_CYCLE_INIT: begin
        if (field_val == '0) step_next = uw.target;
      end
      spsrp_pkg::OP_CYCLE_LOOP: step_next = (cycle_dec == '0) ? uw.target : field_step;
      spsrp_pkg::OP_FRAME_ONLY: begin
        if (field_val[0]) step_next = uw.target;
      end
      spsrp_pkg::OP_CROP: begin
        if (!field_val[0]) step_next = uw.target;
      end
      spsrp_pkg::OP_FINISH: finish = 1'b1;
      default: ;
    endcase
    ends  = too_long || (field_end && finish);
    crop2 = ACC_W'(field_val) << 1;
  end

  // Saturate the accumulated sizes.
  always_comb begin
    w_neg     = acc_w[ACC_W-1];
    h_neg     = acc_h[ACC_W-1];
    w_big     = !w_neg && (acc_w > ACC_W'(spsrp_pkg::SIZE_MAX));
    h_big     = !h_neg && (acc_h > ACC_W'(spsrp_pkg::SIZE_MAX));
    w_sat     = w_neg ? 16'd0 : (w_big ? 16'hFFFF : acc_w[15:0]);
    h_sat     = h_neg ? 16'd0 : (h_big ? 16'hFFFF : acc_h[15:0]);
    out_range = w_neg || w_big || h_neg || h_big;
  end

  always_comb begin
    state_next = state;
    sps.ready  = (state == spsrp_pkg::S_IDLE);
    case (state)
      spsrp_pkg::S_IDLE: begin
        if (take) begin
          if (sps.first_byte) begin
            if (sps.last_byte) state_next = spsrp_pkg::S_EMIT;
          end else if (!parse_done) begin
            if (byte_index == 2'd0) state_next = spsrp_pkg::S_BITS;
            else if (sps.last_byte) state_next = spsrp_pkg::S_EMIT;
          end
        end
      end
      spsrp_pkg::S_BITS: begin
        if (ends) state_next = spsrp_pkg::S_EMIT;
        else if (bit_count == 3'd7) begin
          state_next = last_seen ? spsrp_pkg::S_EMIT : spsrp_pkg::S_IDLE;
        end
      end
      spsrp_pkg::S_EMIT: begin
        if (slot_free) state_next = spsrp_pkg::S_IDLE;
      end
      default: state_next = spsrp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spsrp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_done  <= 1'b1;
      byte_index  <= 2'd0;
      field_step  <= '0;
      code_phase  <= 1'b0;
      zero_count  <= '0;
      suffix_left <= '0;
      res.valid   <= 1'b0;
    end else begin
      if (emit_load) res.valid <= 1'b1;
      else if (res.ready) res.valid <= 1'b0;

      if (take && sps.first_byte) begin
        parse_done  <= sps.last_byte;
        byte_index  <= 2'd1;
        field_step  <= '0;
        code_phase  <= 1'b0;
        zero_count  <= '0;
        suffix_left <= '0;
      end else if (take && !parse_done && byte_index != 2'd0) begin
        byte_index <= byte_index + 2'd1;
        if (sps.last_byte) parse_done <= 1'b1;
      end else if (state == spsrp_pkg::S_BITS) begin
        if (ends) begin
          parse_done <= 1'b1;
        end else begin
          if (field_end) begin
            field_step  <= step_next;
            code_phase  <= 1'b0;
            zero_count  <= '0;
            suffix_left <= '0;
          end else if (!code_phase) begin
            if (!bit_in) zero_count <= zero_count + ZC_W'(1);
            else begin
              code_phase  <= 1'b1;
              suffix_left <= zero_count;
            end
          end else begin
            suffix_left <= suffix_left - ZC_W'(1);
          end
          if (bit_count == 3'd7 && last_seen) parse_done <= 1'b1;
        end
      end
    end
  end

  // Payload and datapath registers.
  always_ff @(posedge clk) begin
    if (emit_load) begin
      res.out_width    <= (pend_status == spsrp_pkg::ST_OK) ? w_sat : 16'd0;
      res.out_height   <= (pend_status == spsrp_pkg::ST_OK) ? h_sat : 16'd0;
      res.is_baseline  <= (profile == spsrp_pkg::PROFILE_BASELINE);
      res.parse_status <= (pend_status == spsrp_pkg::ST_OK && out_range) ?
                          spsrp_pkg::ST_RANGE : pend_status;
    end

    if (take && sps.first_byte) begin
      profile     <= 8'd0;
      acc_w       <= '0;
      acc_h       <= '0;
      pend_status <= spsrp_pkg::ST_TRUNC;
    end else if (take && !parse_done) begin
      if (byte_index == 2'd1) profile <= sps.sps_byte;
      if (byte_index == 2'd0) begin
        shift     <= sps.sps_byte;
        bit_count <= 3'd0;
        last_seen <= sps.last_byte;
      end
      pend_status <= spsrp_pkg::ST_TRUNC;
    end else if (state == spsrp_pkg::S_BITS) begin
      shift     <= shift << 1;
      bit_count <= bit_count + 3'd1;
      if (too_long) begin
        pend_status <= spsrp_pkg::ST_LONG;
      end else if (field_end && finish) begin
        pend_status <= spsrp_pkg::ST_OK;
      end else if (field_end) begin
        case (uw.op)
          spsrp_pkg::OP_CYCLE_INIT: cycle_left <= field_val;
          spsrp_pkg::OP_CYCLE_LOOP: cycle_left <= cycle_dec;
          spsrp_pkg::OP_WIDTH:  acc_w <= (ACC_W'(field_val) + ACC_W'(1)) << spsrp_pkg::MB_SHIFT;
          spsrp_pkg::OP_HEIGHT: acc_h <= (ACC_W'(field_val) + ACC_W'(1)) << spsrp_pkg::MB_SHIFT;
          spsrp_pkg::OP_FRAME_ONLY: begin
            if (!field_val[0]) acc_h <= acc_h << 1;
          end
          spsrp_pkg::OP_CROP_W: acc_w <= acc_w - crop2;
          spsrp_pkg::OP_CROP_H: acc_h <= acc_h - crop2;
          default: ;
        endcase
      end else if (code_phase) begin
        code_value <= code_shift;
      end else if (bit_in) begin
        code_value <= CODE_BITS'(1);
      end
    end
  end

endmodule

// File: design/spsrp_checker.sv
// Port-level checks for the SPS resolution parser, bound to the top level.
// Depends on spsrp_pkg and h264_sps_resolution_parser.
module spsrp_checker (
  input logic        clk,
  input logic        rst,
  input logic        sps_valid,
  input logic        sps_ready,
  input logic        sps_first_byte,
  input logic        sps_last_byte,
  input logic        res_valid,
  input logic        res_ready,
  input logic [15:0] res_out_width,
  input logic [15:0] res_out_height,
  input logic [1:0]  res_parse_status
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result item dropped before it was taken");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_parse_status == spsrp_pkg::ST_TRUNC ||
                  res_parse_status == spsrp_pkg::ST_LONG)
    |-> res_out_width == 16'd0 && res_out_height == 16'd0)
    else $error("error result carries a size");

  a_range_sat: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_parse_status == spsrp_pkg::ST_RANGE
    |-> res_out_width == 16'd0 || res_out_width == 16'hFFFF ||
        res_out_height == 16'd0 || res_out_height == 16'hFFFF)
    else $error("out-of-range status without a saturated size");

  a_lone_header: assert property (@(posedge clk) disable iff (rst)
    sps_valid && sps_ready && sps_first_byte && sps_last_byte |=> !sps_ready)
    else $error("lone header item did not hold the input for its result");

endmodule

bind h264_sps_resolution_parser spsrp_checker u_spsrp_checker (
  .clk              (clk),
  .rst              (rst),
  .sps_valid        (sps.valid),
  .sps_ready        (sps.ready),
  .sps_first_byte   (sps.first_byte),
  .sps_last_byte    (sps.last_byte),
  .res_valid        (res.valid),
  .res_ready        (res.ready),
  .res_out_width    (res.out_width),
  .res_out_height   (res.out_height),
  .res_parse_status (res.parse_status)
);

// File: sim/sps_size_checker.sv
// Checker for the SPS resolution parser: watches both channels, predicts the result of
// each NAL unit from the accepted bytes and compares it with what the block returns.
// Depends on spsrp_pkg, spsrp_byte_if and spsrp_res_if.
module sps_size_checker (
  input  logic   clk,
  input  logic   rst,
  spsrp_byte_if  sps,
  spsrp_res_if   res,
  output int     errors,
  output int     pending
);

  localparam int CODE_LEN   = spsrp_pkg::CODE_BITS_DEF;
  localparam int MB_PIXELS  = 16;

  typedef enum logic [4:0] {
    E_SPS_ID, E_CHROMA, E_LUMA_DEPTH, E_CHROMA_DEPTH, E_QPPRIME, E_SCALING,
    E_LOG2_FRAME, E_POC_TYPE, E_POC_LSB, E_DELTA_ZERO, E_NONREF_OFF, E_TB_OFF,
    E_CYCLE_LEN, E_CYCLE_OFF, E_MAX_REF, E_GAPS, E_WIDTH, E_HEIGHT, E_FRAME_ONLY,
    E_ADAPTIVE, E_DIRECT, E_CROP, E_CROP_L, E_CROP_R, E_CROP_T, E_CROP_B, E_VUI
  } elem_t;

  typedef struct packed {
    logic [15:0]        width;
    logic [15:0]        height;
    logic               baseline;
    spsrp_pkg::status_t status;
  } sps_size_t;

  logic [1:0]  hdr_pos;
  elem_t       elem;
  logic        in_suffix;
  logic [5:0]  lead_zeros;
  logic [5:0]  suffix_left;
  logic [31:0] code_acc;
  logic [7:0]  profile;
  logic [31:0] cycle_left;
  logic [31:0] width_mbs;
  logic [31:0] height_units;
  logic        frame_only;
  logic        crop_on;
  logic [31:0] crop [4];
  logic        idle;
  sps_size_t   size_due [$];
  sps_size_t   want;

  task automatic clear_walker();
    hdr_pos      = 2'd0;
    elem         = E_SPS_ID;
    in_suffix    = 1'b0;
    lead_zeros   = '0;
    suffix_left  = '0;
    code_acc     = '0;
    profile      = '0;
    cycle_left   = '0;
    width_mbs    = '0;
    height_units = '0;
    frame_only   = 1'b0;
    crop_on      = 1'b0;
    crop         = '{default: '0};
    idle         = 1'b1;
  endtask

  task automatic post_size(input logic [15:0] w, input logic [15:0] h,
                           input spsrp_pkg::status_t st);
    sps_size_t s;
    s.width    = w;
    s.height   = h;
    s.baseline = (profile == spsrp_pkg::PROFILE_BASELINE);
    s.status   = st;
    size_due   = {size_due, s};
    idle = 1'b1;
  endtask

  task automatic finish_size();
    longint  w, h, wm, hu, c0, c1, c2, c3;
    spsrp_pkg::status_t st;
    st = spsrp_pkg::ST_OK;
    wm = width_mbs;
    hu = height_units;
    c0 = crop[0];
    c1 = crop[1];
    c2 = crop[2];
    c3 = crop[3];
    w = (wm + 1) * MB_PIXELS - 2 * c0 - 2 * c1;
    h = (frame_only ? 64'sd1 : 64'sd2) * (hu + 1) * MB_PIXELS - 2 * c2 - 2 * c3;
    if (w < 0) begin
      w = 0;
      st = spsrp_pkg::ST_RANGE;
    end else if (w > spsrp_pkg::SIZE_MAX) begin
      w = spsrp_pkg::SIZE_MAX;
      st = spsrp_pkg::ST_RANGE;
    end
    if (h < 0) begin
      h = 0;
      st = spsrp_pkg::ST_RANGE;
    end else if (h > spsrp_pkg::SIZE_MAX) begin
      h = spsrp_pkg::SIZE_MAX;
      st = spsrp_pkg::ST_RANGE;
    end
    post_size(w[15:0], h[15:0], st);
  endtask

  task automatic elem_done(input logic [31:0] v);
    elem_t nxt;
    case (elem)
      E_SPS_ID:    nxt = (profile >= spsrp_pkg::PROFILE_HIGH) ? E_CHROMA : E_LOG2_FRAME;
      E_POC_TYPE:  nxt = (v == 0) ? E_POC_LSB : ((v == 1) ? E_DELTA_ZERO : E_MAX_REF);
      E_POC_LSB:   nxt = E_MAX_REF;
      E_CYCLE_LEN: begin
        cycle_left = v;
        nxt = (v == 0) ? E_MAX_REF : E_CYCLE_OFF;
      end
      E_CYCLE_OFF: begin
        cycle_left = cycle_left - 1;
        nxt = (cycle_left == 0) ? E_MAX_REF : E_CYCLE_OFF;
      end
      E_WIDTH: begin
        width_mbs = v;
        nxt = E_HEIGHT;
      end
      E_HEIGHT: begin
        height_units = v;
        nxt = E_FRAME_ONLY;
      end
      E_FRAME_ONLY: begin
        frame_only = v[0];
        nxt = frame_only ? E_DIRECT : E_ADAPTIVE;
      end
      E_CROP: begin
        crop_on = v[0];
        nxt = crop_on ? E_CROP_L : E_VUI;
      end
      E_CROP_L, E_CROP_R, E_CROP_T, E_CROP_B: begin
        crop[elem - E_CROP_L] = v;
        nxt = elem_t'(elem + 1);
      end
      E_VUI: begin
        finish_size();
        return;
      end
      default: nxt = elem_t'(elem + 1);
    endcase
    elem        = nxt;
    in_suffix   = 1'b0;
    lead_zeros  = '0;
    suffix_left = '0;
    code_acc    = '0;
  endtask

  task automatic take_bit(input logic b);
    logic flag;
    flag = 1'b0;
    case (elem)
      E_QPPRIME, E_SCALING, E_DELTA_ZERO, E_GAPS, E_FRAME_ONLY, E_ADAPTIVE, E_DIRECT,
      E_CROP, E_VUI: flag = 1'b1;
      default: flag = 1'b0;
    endcase
    if (flag) begin
      elem_done({31'd0, b});
    end else if (!in_suffix) begin
      if (!b) begin
        if (lead_zeros >= CODE_LEN - 1) post_size(16'd0, 16'd0, spsrp_pkg::ST_LONG);
        else lead_zeros = lead_zeros + 1;
      end else if (lead_zeros == 0) begin
        elem_done(32'd0);
      end else begin
        in_suffix   = 1'b1;
        suffix_left = lead_zeros;
        code_acc    = 32'd1;
      end
    end else begin
      code_acc    = {code_acc[30:0], b};
      suffix_left = suffix_left - 1;
      if (suffix_left == 0) elem_done(code_acc - 1);
    end
  endtask

  task automatic walk_sps_byte(input logic [7:0] b, input logic first, input logic last);
    int i;
    if (first) begin
      clear_walker();
      idle    = 1'b0;
      hdr_pos = 2'd1;
    end else if (idle) begin
      return;
    end else if (hdr_pos == 2'd1) begin
      profile = b;
      hdr_pos = 2'd2;
    end else if (hdr_pos == 2'd2) begin
      hdr_pos = 2'd3;
    end else if (hdr_pos == 2'd3) begin
      hdr_pos = 2'd0;
    end else begin
      for (i = 7; i >= 0 && !idle; i--) take_bit(b[i]);
      if (idle) return;
    end
    if (last) post_size(16'd0, 16'd0, spsrp_pkg::ST_TRUNC);
  endtask

  task automatic match_field(input string what, input longint exp_v, input longint got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s expected %0d got %0d", $time, what, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_walker();
      size_due.delete();
      errors = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (size_due.size() == 0) begin
          $display("%0t: unexpected result expected none got %0d x %0d status %0d", $time,
                   res.out_width, res.out_height, res.parse_status);
          errors++;
        end else begin
          want = size_due.pop_front();
          match_field("out_width", want.width, res.out_width);
          match_field("out_height", want.height, res.out_height);
          match_field("is_baseline", want.baseline, res.is_baseline);
          match_field("parse_status", int'(want.status), res.parse_status);
        end
      end
      if (sps.valid && sps.ready) walk_sps_byte(sps.sps_byte, sps.first_byte, sps.last_byte);
    end
    pending = size_due.size();
  end

endmodule

// File: sim/tb_h264_sps_resolution_parser.sv
// Testbench top for the SPS resolution parser: builds SPS NAL units bit by bit, feeds them
// with random gaps and back-pressure, and reports the verdict from the checker.
// Depends on spsrp_pkg, both channel interfaces, the parser and sps_size_checker.
module tb_h264_sps_resolution_parser;

  localparam int BYTE_TARGET = 1300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   steady;
  int   fails;
  int   pending;
  int   byte_count;
  int   bad_code = -1;
  int   codes_put;
  bit   sps_bits [$];

  spsrp_byte_if sps_ch ();
  spsrp_res_if  res_ch ();

  h264_sps_resolution_parser u_dut (
    .clk (clk),
    .rst (rst),
    .sps (sps_ch),
    .res (res_ch)
  );

  sps_size_checker u_check (
    .clk     (clk),
    .rst     (rst),
    .sps     (sps_ch),
    .res     (res_ch),
    .errors  (fails),
    .pending (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 15);
    if (r < 90) return $urandom_range(16, 300);
    if (r < 97) return $urandom_range(0, 70000);
    if (r < 99) return $urandom & 32'hFFFF_FFFE;
    return 32'hFFFF_FFFE;
  endfunction

  function automatic logic [31:0] pick_crop();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 32'd0;
    if (r < 90) return $urandom_range(0, 8);
    return pick_code();
  endfunction

  function automatic logic [7:0] pick_profile();
    case ($urandom_range(0, 7))
      0: return spsrp_pkg::PROFILE_BASELINE;
      1: return 8'd77;
      2: return 8'd88;
      3: return spsrp_pkg::PROFILE_HIGH;
      4: return 8'd110;
      5: return 8'd122;
      6: return 8'd244;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic put_flag(input bit b);
    sps_bits = {sps_bits, b};
  endtask

  // unsigned Exp-Golomb; the chosen code is replaced by an over-long run of zeros
  task automatic put_code(input logic [31:0] v);
    logic [32:0] x;
    int          n;
    int          k;
    if (codes_put == bad_code) begin
      repeat ($urandom_range(32, 40)) sps_bits = {sps_bits, 1'b0};
    end else begin
      x = {1'b0, v} + 33'd1;
      n = 32;
      while (!x[n]) n--;
      repeat (n) sps_bits = {sps_bits, 1'b0};
      for (k = n; k >= 0; k--) sps_bits = {sps_bits, x[k]};
    end
    codes_put++;
  endtask

  task automatic build_sps(input logic [7:0] prof, input int bad);
    logic [31:0] poc;
    int          cyc;
    bit          fo;
    bit          cr;
    sps_bits.delete();
    codes_put = 0;
    bad_code  = bad;
    put_code(pick_code());
    if (prof >= spsrp_pkg::PROFILE_HIGH) begin
      put_code(pick_code());
      put_code(pick_code());
      put_code(pick_code());
      put_flag(1'($urandom));
      put_flag(1'($urandom));
    end
    put_code(pick_code());
    case ($urandom_range(0, 9))
      0, 1, 2, 3: poc = 32'd0;
      4, 5, 6:    poc = 32'd1;
      default:    poc = pick_code();
    endcase
    put_code(poc);
    if (poc == 0) begin
      put_code(pick_code());
    end else if (poc == 1) begin
      put_flag(1'($urandom));
      put_code(pick_code());
      put_code(pick_code());
      cyc = $urandom_range(0, 4);
      put_code(cyc);
      repeat (cyc) put_code(pick_code());
    end
    put_code(pick_code());
    put_flag(1'($urandom));
    put_code(pick_code());
    put_code(pick_code());
    fo = 1'($urandom);
    put_flag(fo);
    if (!fo) put_flag(1'($urandom));
    put_flag(1'($urandom));
    cr = 1'($urandom);
    put_flag(cr);
    if (cr) repeat (4) put_code(pick_crop());
    put_flag(1'($urandom));
    bad_code = -1;
  endtask

  task automatic push_byte(input logic [7:0] b, input bit first, input bit last);
    int g;
    g = pick_gap();
    if (g > 0) begin
      sps_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    sps_ch.valid      <= 1'b1;
    sps_ch.sps_byte   <= b;
    sps_ch.first_byte <= first;
    sps_ch.last_byte  <= last;
    @(posedge clk);
    while (!sps_ch.ready) @(posedge clk);
  endtask

  // header, profile and two skipped bytes, then the packed bit stream
  task automatic send_nal(input logic [7:0] prof, input int cut, input bit mark_last,
                          input int extra);
    logic [7:0] nal [$];
    logic [7:0] b;
    int         n;
    int         i;
    int         k;
    nal = {nal, 8'($urandom)};
    nal = {nal, prof};
    nal = {nal, 8'($urandom)};
    nal = {nal, 8'($urandom)};
    while (sps_bits.size() % 8 != 0) sps_bits = {sps_bits, 1'($urandom)};
    while (sps_bits.size() > 0) begin
      for (k = 0; k < 8; k++) b = {b[6:0], sps_bits.pop_front()};
      nal = {nal, b};
    end
    n = nal.size();
    if (cut >= 0 && cut < n) n = cut + 1;
    for (i = 0; i < n + extra; i++) begin
      b = (i < n) ? nal[i] : 8'($urandom);
      push_byte(b, i == 0, mark_last && i == n + extra - 1);
      if (i < n) byte_count++;
    end
  endtask

  task automatic drain();
    sps_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  initial begin
    forever begin
      int g;
      g = pick_gap();
      if (g > 0) begin
        res_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  initial begin
    int kind;
    int next_pause;
    logic [7:0] prof;
    sps_ch.valid      <= 1'b0;
    sps_ch.sps_byte   <= 8'd0;
    sps_ch.first_byte <= 1'b0;
    sps_ch.last_byte  <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // stray byte while idle, header alone marked last, then a unit dropped by a restart
    push_byte(8'($urandom), 1'b0, 1'b1);
    push_byte(8'($urandom), 1'b1, 1'b1);
    push_byte(8'($urandom), 1'b1, 1'b0);
    push_byte(spsrp_pkg::PROFILE_BASELINE, 1'b0, 1'b0);

    sps_bits.delete();
    codes_put = 0;
    bad_code  = 0;
    put_code(32'd0);
    bad_code  = -1;
    send_nal(spsrp_pkg::PROFILE_BASELINE, -1, 1'b1, 0);

    // smallest picture, finishing mid-byte
    sps_bits.delete();
    put_code(0);
    put_code(0);
    put_code(2);
    put_code(0);
    put_flag(0);
    put_code(0);
    put_code(0);
    put_flag(1);
    put_flag(0);
    put_flag(0);
    put_flag(1);
    send_nal(spsrp_pkg::PROFILE_BASELINE, -1, 1'b1, 0);

    // high profile, cycle branch, field coding, crop beyond the width
    sps_bits.delete();
    put_code(0);
    put_code(0);
    put_code(0);
    put_code(0);
    put_flag(0);
    put_flag(0);
    put_code(0);
    put_code(1);
    put_flag(1);
    put_code(0);
    put_code(0);
    put_code(1);
    put_code(5);
    put_code(0);
    put_flag(0);
    put_code(0);
    put_code(0);
    put_flag(0);
    put_flag(1);
    put_flag(1);
    put_flag(1);
    put_code(40);
    put_code(0);
    put_code(0);
    put_code(0);
    put_flag(1);
    send_nal(spsrp_pkg::PROFILE_HIGH, -1, 1'b1, 0);
    drain();

    next_pause = byte_count + 150;
    while (byte_count < BYTE_TARGET) begin
      steady = ($urandom_range(0, 6) == 0);
      prof   = pick_profile();
      kind   = $urandom_range(0, 99);
      if (kind < 65) begin
        build_sps(prof, -1);
        send_nal(prof, -1, $urandom_range(0, 9) != 0,
                 ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
      end else if (kind < 77) begin
        build_sps(prof, -1);
        send_nal(prof, $urandom_range(0, 4 + sps_bits.size() / 8), 1'b1, 0);
      end else if (kind < 84) begin
        build_sps(prof, $urandom_range(0, 10));
        send_nal(prof, -1, 1'b1, 0);
      end else if (kind < 90) begin
        build_sps(prof, -1);
        send_nal(prof, $urandom_range(0, 4 + sps_bits.size() / 8), 1'b0, 0);
      end else if (kind < 95) begin
        sps_bits.delete();
        repeat ($urandom_range(8, 96)) sps_bits = {sps_bits, 1'($urandom)};
        send_nal(prof, -1, 1'b1, 0);
      end else begin
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0, 1'($urandom));
      end
      if (byte_count >= next_pause) begin
        drain();
        next_pause = byte_count + 150;
      end
    end

    steady = 1'b0;
    drain();
    repeat (100) @(posedge clk);
    if (fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// File: h264_sps_resolution_parser.f
design/spsrp_pkg.sv
design/spsrp_byte_if.sv
design/spsrp_res_if.sv
design/h264_sps_resolution_parser.sv
design/spsrp_checker.sv
sim/sps_size_checker.sv
sim/tb_h264_sps_resolution_parser.sv
